// File: design/mst_pkg.sv
// mst_pkg: widths, item and step types, and helpers shared by the
// micropolygon sample test blocks. No dependencies.
`default_nettype none

package mst_pkg;

    localparam int CW   = 24;            // coordinate width, 8 fraction bits
    localparam int DW   = CW + 1;        // coordinate difference
    localparam int MA   = CW + 3;        // multiplier a operand
    localparam int PW   = MA + DW;       // one product
    localparam int SW   = PW + 1;        // sum or difference of two products
    localparam int NW   = 2 * CW + 3;    // plane normal component
    localparam int LW   = CW + 2;        // low limb of a normal component
    localparam int NUMW = 3 * CW + 5;    // depth numerator
    localparam int RW   = NW + 1;        // divider partial remainder
    localparam int CNTW = $clog2(CW + 1);
    localparam int QD   = 2;             // queue depth
    localparam int QPW  = $clog2(QD);
    localparam int QCW  = $clog2(QD + 1);

    typedef enum logic [1:0] {
        K_LOAD,
        K_SETUP,
        K_SAMPLE,
        K_SAMPLE_NL
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [1:0]           idx;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } item_t;

    typedef enum logic [3:0] {
        S_ORD, S_NX, S_NY, S_NZ,
        S_E0, S_E1, S_E2, S_E3,
        S_NHI, S_NLO
    } step_t;

    typedef enum logic [2:0] {
        B_IDLE, B_RUN, B_DRAIN, B_EVAL, B_DIVGO, B_DIV, B_DONE
    } bstate_t;

    typedef enum logic [1:0] {
        D_IDLE, D_ABS, D_CHK, D_ITER
    } dstate_t;

    // request to the dual multiplier
    typedef struct packed {
        logic                 valid;
        step_t                step;
        logic                 sub;
        logic signed [MA-1:0] a1;
        logic signed [DW-1:0] b1;
        logic signed [MA-1:0] a2;
        logic signed [DW-1:0] b2;
    } mreq_t;

    typedef struct packed {
        logic                 valid;
        step_t                step;
        logic signed [SW-1:0] s;
    } mres_t;

    typedef struct packed {
        logic          done;
        logic          ovf;
        logic          neg;
        logic [CW-1:0] mag;
    } dres_t;

    function automatic logic signed [DW-1:0] diff(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
        diff = DW'(a) - DW'(b);
    endfunction

endpackage

`default_nettype wire

// File: design/mst_queue.sv
// mst_queue: short fifo of classified requests between front and back.
// Depends on mst_pkg.
`default_nettype none

module mst_queue
    import mst_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_item,
    input  wire logic  pop,
    output logic       full,
    output logic       empty,
    output item_t      head
);

    item_t            mem_reg [QD];
    logic [QPW-1:0]   wp_reg;
    logic [QPW-1:0]   rp_reg;
    logic [QCW-1:0]   cnt_reg;

    assign full  = (cnt_reg == QCW'(QD));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + QPW'(1);
            if (pop)
                rp_reg <= rp_reg + QPW'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + QCW'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_item;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop) else $error("queue pop while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCW'(QD)) else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

// File: design/mst_front.sv
// mst_front: accepts requests, tracks which corners are loaded and tags
// each request for the back end. Depends on mst_pkg.
`default_nettype none

module mst_front
    import mst_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 mode,
    input  wire logic [1:0]           vertex_index,
    input  wire logic signed [CW-1:0] coord_x,
    input  wire logic signed [CW-1:0] coord_y,
    input  wire logic signed [CW-1:0] coord_z,
    input  wire logic                 q_full,
    output logic                      push,
    output item_t                     push_item
);

    logic [3:0] mask_reg;
    logic [3:0] mask_next;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        mask_next      = mask_reg;
        push_item.idx  = vertex_index;
        push_item.x    = coord_x;
        push_item.y    = coord_y;
        push_item.z    = coord_z;
        if (!mode)
        begin
            mask_next      = mask_reg | (4'b0001 << vertex_index);
            push_item.kind = (mask_next == 4'hF) ? K_SETUP : K_LOAD;
        end
        else
        begin
            push_item.kind = (mask_reg == 4'hF) ? K_SAMPLE : K_SAMPLE_NL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= '0;
        else if (push)
            mask_reg <= mask_next;
    end

endmodule

`default_nettype wire

// File: design/mst_mul2.sv
// mst_mul2: two signed multipliers with registered products, and their
// sum or difference. Depends on mst_pkg.
`default_nettype none

module mst_mul2
    import mst_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire mreq_t req,
    output mres_t      res
);

    logic signed [PW-1:0] p1_reg;
    logic signed [PW-1:0] p2_reg;
    logic                 sub_reg;
    logic                 valid_reg;
    step_t                step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        p1_reg   <= PW'(req.a1) * PW'(req.b1);
        p2_reg   <= PW'(req.a2) * PW'(req.b2);
        sub_reg  <= req.sub;
        step_reg <= req.step;
    end

    assign res.valid = valid_reg;
    assign res.step  = step_reg;
    assign res.s     = sub_reg ? (SW'(p1_reg) - SW'(p2_reg)) : (SW'(p1_reg) + SW'(p2_reg));

endmodule

`default_nettype wire

// File: design/mst_div.sv
// mst_div: signed quotient of the depth numerator by normal z, truncated
// toward zero, one quotient bit a cycle, with early overflow detect.
// Depends on mst_pkg.
`default_nettype none

module mst_div
    import mst_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic signed [NUMW-1:0] num,
    input  wire logic signed [NW-1:0]   den,
    output dres_t                       res
);

    dstate_t          st_reg;
    dstate_t          st_next;
    logic [NUMW-1:0]  nabs_reg;
    logic [NW-1:0]    dabs_reg;
    logic             neg_reg;
    logic             ovf_reg;
    logic [RW-1:0]    rem_reg;
    logic [CW-1:0]    low_reg;
    logic [CNTW-1:0]  cnt_reg;
    logic             done_reg;
    logic             done_next;
    logic [RW-1:0]    sh;
    logic             big;

    assign sh  = {rem_reg[RW-2:0], low_reg[CW-1]};
    assign big = (nabs_reg[NUMW-1:CW] >= (NUMW-CW)'(dabs_reg));

    always_comb
    begin
        st_next   = st_reg;
        done_next = 1'b0;
        unique case (st_reg)
            D_IDLE: if (start) st_next = D_ABS;
            D_ABS:  st_next = D_CHK;
            D_CHK:
            begin
                if (big)
                begin
                    st_next   = D_IDLE;
                    done_next = 1'b1;
                end
                else
                    st_next = D_ITER;
            end
            D_ITER:
            begin
                if (cnt_reg == CNTW'(CW - 1))
                begin
                    st_next   = D_IDLE;
                    done_next = 1'b1;
                end
            end
            default: st_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= D_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    nabs_reg <= num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
                    dabs_reg <= den[NW-1] ? NW'(-den) : NW'(den);
                    neg_reg  <= num[NUMW-1] ^ den[NW-1];
                end
            end
            D_ABS:
            begin
                rem_reg <= nabs_reg[CW+RW-1:CW];
                low_reg <= nabs_reg[CW-1:0];
                cnt_reg <= '0;
            end
            D_CHK:
                ovf_reg <= big;
            D_ITER:
            begin
                if (sh >= {1'b0, dabs_reg})
                begin
                    rem_reg <= sh - {1'b0, dabs_reg};
                    low_reg <= {low_reg[CW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= sh;
                    low_reg <= {low_reg[CW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + CNTW'(1);
            end
            default: ;
        endcase
    end

    assign res.done = done_reg;
    assign res.ovf  = ovf_reg;
    assign res.neg  = neg_reg;
    assign res.mag  = low_reg;

endmodule

`default_nettype wire

// File: design/mst_back.sv
// mst_back: holds the corners and plane, sequences setup and sample work
// over the shared multiplier pair and divider, and owns the result register.
// Depends on mst_pkg, mst_mul2, mst_div.
`default_nettype none

module mst_back
    import mst_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_empty,
    input  wire item_t         head,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic               hit,
    output logic signed [CW-1:0] depth,
    output logic               depth_saturated,
    output logic               plane_degenerate,
    output logic               not_loaded
);

    bstate_t st_reg;
    bstate_t st_next;
    step_t   step_reg;
    step_t   step_next;

    logic signed [CW-1:0] cx_reg [4];
    logic signed [CW-1:0] cy_reg [4];
    logic signed [CW-1:0] cz_reg [4];
    logic signed [CW-1:0] sx_reg;
    logic signed [CW-1:0] sy_reg;
    logic                 flip_reg;
    logic signed [NW-1:0] nx_reg;
    logic signed [NW-1:0] ny_reg;
    logic signed [NW-1:0] nz_reg;
    logic signed [SW-1:0] nhi_reg;
    logic signed [SW-1:0] nlo_reg;
    logic signed [NUMW-1:0] num_reg;
    logic                 inside_reg;
    logic                 nl_reg;
    logic                 dg_reg;

    logic                 out_valid_reg;
    logic                 hit_reg;
    logic signed [CW-1:0] depth_reg;
    logic                 sat_reg;
    logic                 odg_reg;
    logic                 onl_reg;

    mreq_t req;
    mres_t mres;
    dres_t dres;
    logic  div_start;
    logic  out_free;
    logic  last_step;

    logic signed [DW-1:0] ubx, uby, ubz, ucx, ucy, ucz, dxs, dys;
    logic signed [CW-1:0] x0, y0, xq, yq;
    logic signed [NUMW-1:0] num_sum;
    logic signed [CW+1:0] qv;
    logic signed [CW+1:0] tot;
    logic signed [CW-1:0] maxv;
    logic signed [CW-1:0] minv;
    logic signed [CW-1:0] dep;
    logic                 sat;

    mst_mul2 u_mul (.clk(clk), .rst_n(rst_n), .req(req), .res(mres));

    mst_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (nz_reg),
        .res   (dres)
    );

    assign out_free  = !out_valid_reg || out_ready;
    assign pop       = (st_reg == B_IDLE) && !q_empty;
    assign div_start = (st_reg == B_DIVGO);
    assign last_step = (step_reg == S_NZ) || (step_reg == S_NLO);

    assign ubx = diff(cx_reg[1], cx_reg[0]);
    assign uby = diff(cy_reg[1], cy_reg[0]);
    assign ubz = diff(cz_reg[1], cz_reg[0]);
    assign ucx = diff(cx_reg[2], cx_reg[0]);
    assign ucy = diff(cy_reg[2], cy_reg[0]);
    assign ucz = diff(cz_reg[2], cz_reg[0]);
    assign dxs = diff(cx_reg[0], sx_reg);
    assign dys = diff(cy_reg[0], sy_reg);

    // edge endpoints along the chosen walk
    always_comb
    begin
        x0 = cx_reg[0];
        y0 = cy_reg[0];
        xq = cx_reg[1];
        yq = cy_reg[1];
        case (step_reg)
            S_E0:
            begin
                x0 = cx_reg[0];
                y0 = cy_reg[0];
                xq = flip_reg ? cx_reg[3] : cx_reg[1];
                yq = flip_reg ? cy_reg[3] : cy_reg[1];
            end
            S_E1:
            begin
                x0 = flip_reg ? cx_reg[3] : cx_reg[1];
                y0 = flip_reg ? cy_reg[3] : cy_reg[1];
                xq = cx_reg[2];
                yq = cy_reg[2];
            end
            S_E2:
            begin
                x0 = cx_reg[2];
                y0 = cy_reg[2];
                xq = flip_reg ? cx_reg[1] : cx_reg[3];
                yq = flip_reg ? cy_reg[1] : cy_reg[3];
            end
            S_E3:
            begin
                x0 = flip_reg ? cx_reg[1] : cx_reg[3];
                y0 = flip_reg ? cy_reg[1] : cy_reg[3];
                xq = cx_reg[0];
                yq = cy_reg[0];
            end
            default: ;
        endcase
    end

    always_comb
    begin
        req.valid = (st_reg == B_RUN);
        req.step  = step_reg;
        req.sub   = 1'b1;
        req.a1    = '0;
        req.b1    = '0;
        req.a2    = '0;
        req.b2    = '0;
        unique case (step_reg)
            S_ORD:
            begin
                req.a1 = MA'(diff(cx_reg[0], cx_reg[1]));
                req.b1 = diff(cy_reg[1], cy_reg[2]);
                req.a2 = MA'(diff(cy_reg[0], cy_reg[1]));
                req.b2 = diff(cx_reg[1], cx_reg[2]);
            end
            S_NX:
            begin
                req.a1 = MA'(uby); req.b1 = ucz;
                req.a2 = MA'(ubz); req.b2 = ucy;
            end
            S_NY:
            begin
                req.a1 = MA'(ubz); req.b1 = ucx;
                req.a2 = MA'(ubx); req.b2 = ucz;
            end
            S_NZ:
            begin
                req.a1 = MA'(ubx); req.b1 = ucy;
                req.a2 = MA'(uby); req.b2 = ucx;
            end
            S_E0, S_E1, S_E2, S_E3:
            begin
                req.a1 = MA'(diff(sy_reg, y0)); req.b1 = diff(xq, x0);
                req.a2 = MA'(diff(sx_reg, x0)); req.b2 = diff(yq, y0);
            end
            S_NHI:
            begin
                req.sub = 1'b0;
                req.a1  = MA'($signed(nx_reg[NW-1:LW])); req.b1 = dxs;
                req.a2  = MA'($signed(ny_reg[NW-1:LW])); req.b2 = dys;
            end
            S_NLO:
            begin
                req.sub = 1'b0;
                req.a1  = $signed({1'b0, nx_reg[LW-1:0]}); req.b1 = dxs;
                req.a2  = $signed({1'b0, ny_reg[LW-1:0]}); req.b2 = dys;
            end
            default: ;
        endcase
    end

    // upper and lower partial sums of the numerator
    assign num_sum = (NUMW'(nhi_reg) <<< LW) + NUMW'(nlo_reg);

    always_comb
    begin
        maxv = {1'b0, {(CW-1){1'b1}}};
        minv = {1'b1, {(CW-1){1'b0}}};
        qv   = dres.neg ? -(CW+2)'(dres.mag) : (CW+2)'(dres.mag);
        tot  = (CW+2)'(cz_reg[0]) + qv;
        sat  = 1'b0;
        dep  = tot[CW-1:0];
        if (dres.ovf)
        begin
            sat = 1'b1;
            dep = dres.neg ? minv : maxv;
        end
        else if (tot > (CW+2)'(maxv))
        begin
            sat = 1'b1;
            dep = maxv;
        end
        else if (tot < (CW+2)'(minv))
        begin
            sat = 1'b1;
            dep = minv;
        end
    end

    always_comb
    begin
        st_next   = st_reg;
        step_next = step_reg;
        unique case (st_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    unique case (head.kind)
                        K_LOAD:      st_next = B_IDLE;
                        K_SETUP:
                        begin
                            st_next   = B_RUN;
                            step_next = S_ORD;
                        end
                        K_SAMPLE_NL: st_next = B_DONE;
                        K_SAMPLE:
                        begin
                            if (nz_reg == '0)
                                st_next = B_DONE;
                            else
                            begin
                                st_next   = B_RUN;
                                step_next = S_E0;
                            end
                        end
                        default:     st_next = B_IDLE;
                    endcase
                end
            end
            B_RUN:
            begin
                if (last_step)
                    st_next = B_DRAIN;
                else
                    step_next = step_t'(step_reg + 4'd1);
            end
            B_DRAIN: st_next = (step_reg == S_NZ) ? B_IDLE : B_EVAL;
            B_EVAL:  st_next = inside_reg ? B_DIVGO : B_DONE;
            B_DIVGO: st_next = B_DIV;
            B_DIV:   if (dres.done) st_next = B_DONE;
            B_DONE:  if (out_free) st_next = B_IDLE;
            default: st_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= B_IDLE;
            step_reg      <= S_ORD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            step_reg <= step_next;
            if ((st_reg == B_DONE) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if ((head.kind == K_LOAD) || (head.kind == K_SETUP))
            begin
                cx_reg[head.idx] <= head.x;
                cy_reg[head.idx] <= head.y;
                cz_reg[head.idx] <= head.z;
            end
            sx_reg     <= head.x;
            sy_reg     <= head.y;
            nl_reg     <= (head.kind == K_SAMPLE_NL);
            dg_reg     <= (head.kind == K_SAMPLE) && (nz_reg == '0);
            inside_reg <= (head.kind == K_SAMPLE) && (nz_reg != '0);
        end
        if (mres.valid)
        begin
            case (mres.step)
                S_ORD: flip_reg <= mres.s[SW-1] || (mres.s == '0);
                S_NX:  nx_reg <= mres.s[NW-1:0];
                S_NY:  ny_reg <= mres.s[NW-1:0];
                S_NZ:  nz_reg <= mres.s[NW-1:0];
                S_NHI: nhi_reg <= mres.s;
                S_NLO: nlo_reg <= mres.s;
                S_E0, S_E1, S_E2, S_E3:
                    if (mres.s[SW-1]) inside_reg <= 1'b0;
                default: ;
            endcase
        end
        if (st_reg == B_EVAL)
            num_reg <= num_sum;
        if ((st_reg == B_DONE) && out_free)
        begin
            hit_reg   <= inside_reg;
            depth_reg <= inside_reg ? dep : '0;
            sat_reg   <= inside_reg && sat;
            odg_reg   <= dg_reg;
            onl_reg   <= nl_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign hit              = hit_reg;
    assign depth            = depth_reg;
    assign depth_saturated  = sat_reg;
    assign plane_degenerate = odg_reg;
    assign not_loaded       = onl_reg;

`ifndef SYNTHESIS
    a_hit_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !not_loaded && !plane_degenerate)
        else $error("hit with not_loaded or degenerate plane");
    a_sat_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && depth_saturated |-> hit)
        else $error("saturated depth on a miss");
    a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == B_IDLE) |-> !mres.valid)
        else $error("product arrived while back end idle");
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        dres.done |-> (st_reg == B_DIV))
        else $error("divider finished outside divide state");
`endif

endmodule

`default_nettype wire

// File: design/micropolygon_sample_test.sv
// micropolygon_sample_test: top level, front classifier, request queue and
// back end. Depends on mst_pkg, mst_front, mst_queue, mst_back.
//
//   channel | handshake            | payload
//   input   | in_valid / in_ready  | mode, vertex_index, coord_x, coord_y, coord_z
//   output  | out_valid / out_ready| hit, depth, depth_saturated, plane_degenerate,
//           |                      | not_loaded
//
// a load is taken by the back end straight from idle; the load that completes
// the quad adds setup on the shared multiplier pair.
// a sample inside the quad runs the edge tests and numerator on the multiplier
// pair, then the one bit per cycle divider, which stops early when it flags an
// overflow up front; a miss skips the divider, a not_loaded or degenerate sample both.
// the two entry queue lets requests be accepted while the back end works or
// while a result waits in the output register. no clearing pass after reset.
`default_nettype none

module micropolygon_sample_test
    import mst_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 mode,
    input  wire logic [1:0]           vertex_index,
    input  wire logic signed [CW-1:0] coord_x,
    input  wire logic signed [CW-1:0] coord_y,
    input  wire logic signed [CW-1:0] coord_z,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      hit,
    output logic signed [CW-1:0]      depth,
    output logic                      depth_saturated,
    output logic                      plane_degenerate,
    output logic                      not_loaded
);

    logic  q_full;
    logic  q_empty;
    logic  push;
    logic  pop;
    item_t push_item;
    item_t head;

    mst_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .vertex_index (vertex_index),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .q_full       (q_full),
        .push         (push),
        .push_item    (push_item)
    );

    mst_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (head)
    );

    mst_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (q_empty),
        .head             (head),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .hit              (hit),
        .depth            (depth),
        .depth_saturated  (depth_saturated),
        .plane_degenerate (plane_degenerate),
        .not_loaded       (not_loaded)
    );

endmodule

`default_nettype wire

// File: test/testbench.sv
// testbench: self-checking test of micropolygon_sample_test, corner loads and
// sample requests checked against a behavioral quad coverage and depth model.
// Depends on mst_pkg and the micropolygon_sample_test RTL.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mst_pkg::*;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;
    localparam int   WATCH_LIMIT = 20000;
    localparam int   SETTLE      = 60;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] depth;
        logic                 sat;
        logic                 degen;
        logic                 nload;
    } sample_res_t;

    typedef struct {
        logic                 mode;
        logic [1:0]           idx;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 known;
        sample_res_t          res;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 mode;
    logic [1:0]           vertex_index;
    logic signed [CW-1:0] coord_x;
    logic signed [CW-1:0] coord_y;
    logic signed [CW-1:0] coord_z;
    logic                 out_valid;
    logic                 out_ready;
    logic                 hit;
    logic signed [CW-1:0] depth;
    logic                 depth_saturated;
    logic                 plane_degenerate;
    logic                 not_loaded;

    micropolygon_sample_test u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .vertex_index(vertex_index),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .hit(hit), .depth(depth), .depth_saturated(depth_saturated),
        .plane_degenerate(plane_degenerate), .not_loaded(not_loaded)
    );

    // quad state mirrored by the predictor
    logic signed [63:0]  qx [4];
    logic signed [63:0]  qy [4];
    logic signed [63:0]  qz [4];
    logic [3:0]          corner_mask;
    logic                walk_flipped;
    logic signed [127:0] nrm_x, nrm_y, nrm_z;

    sample_res_t expected_samples[$];
    int errors;
    int samples_seen, hits_seen, loads_sent;
    int send_idle_pct, recv_idle_pct;
    int idle_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    function automatic void quad_setup();
        logic signed [127:0] bx, by, bz, cx, cy, cz, lhs, rhs;
        bx = 128'(qx[1] - qx[0]); by = 128'(qy[1] - qy[0]); bz = 128'(qz[1] - qz[0]);
        cx = 128'(qx[2] - qx[0]); cy = 128'(qy[2] - qy[0]); cz = 128'(qz[2] - qz[0]);
        lhs = 128'(qx[0] - qx[1]) * 128'(qy[1] - qy[2]);
        rhs = 128'(qy[0] - qy[1]) * 128'(qx[1] - qx[2]);
        walk_flipped = (rhs < lhs) ? 1'b0 : 1'b1;
        nrm_x = by * cz - bz * cy;
        nrm_y = bz * cx - bx * cz;
        nrm_z = bx * cy - by * cx;
    endfunction

    function automatic logic edge_inside(input int p, input int q,
                                         input logic signed [63:0] sx,
                                         input logic signed [63:0] sy);
        logic signed [127:0] e;
        e = 128'(sy - qy[p]) * 128'(qx[q] - qx[p]) - 128'(sx - qx[p]) * 128'(qy[q] - qy[p]);
        return e >= 0;
    endfunction

    // applies one accepted request; returns 1 when a result is expected
    function automatic logic quad_apply(input logic m, input logic [1:0] vi,
                                        input logic signed [CW-1:0] x,
                                        input logic signed [CW-1:0] y,
                                        input logic signed [CW-1:0] z,
                                        output sample_res_t r);
        int walk[4];
        logic is_in;
        logic signed [127:0] num, quo, tot, hi_lim, lo_lim;
        r = '{1'b0, '0, 1'b0, 1'b0, 1'b0};
        if (m == MODE_LOAD)
        begin
            qx[vi] = 64'(x); qy[vi] = 64'(y); qz[vi] = 64'(z);
            corner_mask[vi] = 1'b1;
            if (&corner_mask) quad_setup();
            return 1'b0;
        end
        if (!(&corner_mask))
        begin
            r.nload = 1'b1;
            return 1'b1;
        end
        if (nrm_z == 0)
        begin
            r.degen = 1'b1;
            return 1'b1;
        end
        walk[0] = 0; walk[2] = 2;
        walk[1] = walk_flipped ? 3 : 1;
        walk[3] = walk_flipped ? 1 : 3;
        is_in = 1'b1;
        for (int k = 0; k < 4; k++)
            if (!edge_inside(walk[k], walk[(k + 1) % 4], 64'(x), 64'(y))) is_in = 1'b0;
        if (!is_in) return 1'b1;
        num = nrm_x * 128'(qx[0] - x) + nrm_y * 128'(qy[0] - y);
        quo = num / nrm_z;   // signed division truncates toward zero
        tot = 128'(qz[0]) + quo;
        hi_lim = (128'sd1 <<< (CW - 1)) - 1;
        lo_lim = -hi_lim - 1;
        r.hit = 1'b1;
        if (tot > hi_lim)
        begin
            r.depth = hi_lim[CW-1:0]; r.sat = 1'b1;
        end
        else if (tot < lo_lim)
        begin
            r.depth = lo_lim[CW-1:0]; r.sat = 1'b1;
        end
        else
            r.depth = tot[CW-1:0];
        return 1'b1;
    endfunction

    task automatic send_request(input logic m, input logic [1:0] vi,
                                input logic signed [CW-1:0] x,
                                input logic signed [CW-1:0] y,
                                input logic signed [CW-1:0] z,
                                input logic known, input sample_res_t want);
        sample_res_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= m;
        vertex_index <= vi;
        coord_x      <= x;
        coord_y      <= y;
        coord_z      <= z;
        do @(posedge clk); while (!in_ready);
        if (quad_apply(m, vi, x, y, z, r))
        begin
            if (known && r != want)
                report_mismatch("predictor vs table row", r.depth, want.depth);
            expected_samples.push_back(known ? want : r);
        end
        else
            loads_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_samples.size() != 0) @(posedge clk);
    endtask

    // receiver side and result checks
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                sample_res_t w;
                if (expected_samples.size() == 0)
                    report_mismatch("unexpected result", 1, 0);
                else
                begin
                    w = expected_samples.pop_front();
                    samples_seen++;
                    if (hit) hits_seen++;
                    if (hit !== w.hit) report_mismatch("hit", hit, w.hit);
                    if (depth !== w.depth) report_mismatch("depth", depth, w.depth);
                    if (depth_saturated !== w.sat)
                        report_mismatch("depth_saturated", depth_saturated, w.sat);
                    if (plane_degenerate !== w.degen)
                        report_mismatch("plane_degenerate", plane_degenerate, w.degen);
                    if (not_loaded !== w.nload)
                        report_mismatch("not_loaded", not_loaded, w.nload);
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
        else
            out_ready <= 1'b0;
    end

    // watchdog on cycles with no accepted request or result
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic signed [CW-1:0] rand_coord(input int span);
        if (span == 0) return CW'($urandom);
        return CW'($signed($urandom_range(2 * span)) - span);
    endfunction

    // random quad, usually of small extent, around a center, plus samples near it
    task automatic random_quad_and_samples(input int nsamp);
        logic signed [CW-1:0] cx, cy;
        int span;
        sample_res_t none;
        none = '{1'b0, '0, 1'b0, 1'b0, 1'b0};
        span = ($urandom_range(9) == 0) ? 2000000 : $urandom_range(4000) + 1;
        cx = rand_coord(($urandom_range(4) == 0) ? 0 : 3000000);
        cy = rand_coord(($urandom_range(4) == 0) ? 0 : 3000000);
        for (int i = 0; i < 4; i++)
        begin
            // square-ish corners so many samples land inside
            logic signed [CW-1:0] ox, oy;
            ox = (i == 1 || i == 2) ? CW'(span) : CW'(-span);
            oy = (i >= 2) ? CW'(span) : CW'(-span);
            if ($urandom_range(1)) ox = -ox;
            send_request(MODE_LOAD, 2'(i), cx + ox + rand_coord(span / 4),
                         cy + oy + rand_coord(span / 4), rand_coord(0), 1'b0, none);
        end
        for (int i = 0; i < nsamp; i++)
            send_request(MODE_SAMPLE, 2'($urandom), cx + rand_coord(span + span / 2),
                         cy + rand_coord(span + span / 2), CW'($urandom), 1'b0, none);
    endtask

    stim_row_t directed[$];

    task automatic add_row(input logic m, input logic [1:0] vi, input int x, input int y,
                           input int z, input logic known, input sample_res_t r);
        stim_row_t s;
        s.mode = m; s.idx = vi; s.x = CW'(x); s.y = CW'(y); s.z = CW'(z);
        s.known = known; s.res = r;
        directed.push_back(s);
    endtask

    initial
    begin
        sample_res_t none, nl, dg, miss;
        int maxc, minc;
        none = '{1'b0, '0, 1'b0, 1'b0, 1'b0};
        nl   = '{1'b0, '0, 1'b0, 1'b0, 1'b1};
        dg   = '{1'b0, '0, 1'b0, 1'b1, 1'b0};
        miss = none;
        maxc = (1 <<< (CW - 1)) - 1;
        minc = -maxc - 1;

        rst_n = 1'b0; in_valid = 1'b0; mode = 1'b0;
        vertex_index = '0; coord_x = '0; coord_y = '0; coord_z = '0;
        corner_mask = '0; walk_flipped = 1'b0;
        nrm_x = 0; nrm_y = 0; nrm_z = 0;
        errors = 0; samples_seen = 0; hits_seen = 0; loads_sent = 0;
        send_idle_pct = 8; recv_idle_pct = 77;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sample before load, partial load
        add_row(MODE_SAMPLE, 0, 0, 0, 0, 1'b1, nl);
        add_row(MODE_LOAD, 0, 0, 0, 256, 1'b0, none);
        add_row(MODE_SAMPLE, 3, maxc, minc, maxc, 1'b1, nl);
        // collinear corners give zero normal z
        add_row(MODE_LOAD, 1, 256, 0, 0, 1'b0, none);
        add_row(MODE_LOAD, 2, 512, 0, 0, 1'b0, none);
        add_row(MODE_LOAD, 3, 768, 0, 0, 1'b0, none);
        add_row(MODE_SAMPLE, 0, 256, 0, 0, 1'b1, dg);
        // reload after complete: square, flat at z=256
        add_row(MODE_LOAD, 1, 0, 2560, 256, 1'b0, none);
        add_row(MODE_LOAD, 2, 2560, 2560, 256, 1'b0, none);
        add_row(MODE_LOAD, 3, 2560, 0, 256, 1'b0, none);
        add_row(MODE_LOAD, 0, 0, 0, 256, 1'b0, none);
        add_row(MODE_SAMPLE, 0, 1280, 1280, 0, 1'b1, '{1'b1, 24'sd256, 1'b0, 1'b0, 1'b0});
        add_row(MODE_SAMPLE, 0, 0, 0, 0, 1'b1, '{1'b1, 24'sd256, 1'b0, 1'b0, 1'b0});
        add_row(MODE_SAMPLE, 0, 2560, 1280, 0, 1'b1, '{1'b1, 24'sd256, 1'b0, 1'b0, 1'b0});
        add_row(MODE_SAMPLE, 0, maxc, maxc, 0, 1'b1, miss);
        add_row(MODE_SAMPLE, 0, minc, minc, 0, 1'b1, miss);
        // plane that spans the full depth range, opposite winding
        add_row(MODE_LOAD, 0, minc, minc, maxc, 1'b0, none);
        add_row(MODE_LOAD, 1, maxc, minc, minc, 1'b0, none);
        add_row(MODE_LOAD, 2, maxc, maxc, minc, 1'b0, none);
        add_row(MODE_LOAD, 3, minc, maxc, maxc, 1'b0, none);
        add_row(MODE_SAMPLE, 0, 0, 0, 0, 1'b0, none);
        add_row(MODE_SAMPLE, 0, maxc, 0, 0, 1'b0, none);
        add_row(MODE_SAMPLE, 0, -100, 5, 0, 1'b0, none);

        foreach (directed[i])
            send_request(directed[i].mode, directed[i].idx, directed[i].x, directed[i].y,
                         directed[i].z, directed[i].known, directed[i].res);

        for (int ph = 0; ph < 3; ph++)
        begin
            int quads;
            if (ph == 1)
            begin
                send_idle_pct = 77; recv_idle_pct = 8;
            end
            else if (ph == 2)
            begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            quads = 0;
            while (quads < 40)
            begin
                if ($urandom_range(9) == 0)
                    // noise: fully random request
                    send_request($urandom_range(1), 2'($urandom), CW'($urandom), CW'($urandom),
                                 CW'($urandom), 1'b0, none);
                else
                begin
                    random_quad_and_samples($urandom_range(12) + 1);
                    quads++;
                end
                if (quads == 20) wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        $display("covered %0d corner loads and %0d samples, %0d of them hits",
                 loads_sent, samples_seen, hits_seen);
        if (errors == 0 && expected_samples.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

`default_nettype wire
